### rtl/hdte_pkg.sv
package hdte_pkg;

  // result status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_SYNTAX = 2'd1;
  localparam logic [1:0] ST_YEAR   = 2'd2;
  localparam logic [1:0] ST_WDAY   = 2'd3;

  // register indexes
  localparam logic REG_ALLOW_DASH = 1'b0;

  // format masks
  localparam logic [2:0] FMT_ALL  = 3'd7;
  localparam logic [2:0] FMT_1123 = 3'd1;
  localparam logic [2:0] FMT_850  = 3'd2;
  localparam logic [2:0] FMT_ASC  = 3'd4;

  localparam logic [13:0] YEAR_BASE = 14'd1970;
  localparam int unsigned SEC_PER_DAY = 86400;

  // template slot kinds
  localparam logic [3:0] K_LIT     = 4'd0;
  localparam logic [3:0] K_DAY     = 4'd1;
  localparam logic [3:0] K_DAYSP   = 4'd2;
  localparam logic [3:0] K_YEAR    = 4'd3;
  localparam logic [3:0] K_HOUR    = 4'd4;
  localparam logic [3:0] K_MIN     = 4'd5;
  localparam logic [3:0] K_SEC     = 4'd6;
  localparam logic [3:0] K_SEP     = 4'd7;
  localparam logic [3:0] K_MON     = 4'd8;
  localparam logic [3:0] K_MONLAST = 4'd9;
  localparam logic [3:0] K_END     = 4'd10;

  typedef struct packed {
    logic [3:0] kind;
    logic [7:0] lit;
    logic       fin;
  } tpl_t;

  // fields handed from the parser to the epoch pipeline
  typedef struct packed {
    logic        failed;
    logic        complete;
    logic [2:0]  wd;
    logic [3:0]  mon;
    logic [6:0]  day;
    logic [13:0] year;
    logic [6:0]  hour;
    logic [6:0]  minute;
    logic [6:0]  second;
  } fields_t;

  function automatic logic [3:0] wd_lookup(input logic [23:0] s);
    logic [3:0] r;
    unique case (s)
      "Thu":   r = 4'b1000;
      "Fri":   r = 4'b1001;
      "Sat":   r = 4'b1010;
      "Sun":   r = 4'b1011;
      "Mon":   r = 4'b1100;
      "Tue":   r = 4'b1101;
      "Wed":   r = 4'b1110;
      default: r = 4'b0000;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] mon_lookup(input logic [23:0] s);
    logic [4:0] r;
    unique case (s)
      "Jan":   r = 5'h10;
      "Feb":   r = 5'h11;
      "Mar":   r = 5'h12;
      "Apr":   r = 5'h13;
      "May":   r = 5'h14;
      "Jun":   r = 5'h15;
      "Jul":   r = 5'h16;
      "Aug":   r = 5'h17;
      "Sep":   r = 5'h18;
      "Oct":   r = 5'h19;
      "Nov":   r = 5'h1A;
      "Dec":   r = 5'h1B;
      default: r = 5'h00;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] wk_len(input logic [2:0] wd);
    logic [3:0] r;
    unique case (wd)
      3'd0:    r = 4'd8;
      3'd1:    r = 4'd6;
      3'd2:    r = 4'd8;
      3'd3:    r = 4'd6;
      3'd4:    r = 4'd6;
      3'd5:    r = 4'd7;
      3'd6:    r = 4'd9;
      default: r = 4'd0;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] wk_char(input logic [2:0] wd, input logic [3:0] p);
    logic [71:0] s;
    logic [71:0] sh;
    unique case (wd)
      3'd0:    s = {"Thursday", 8'h00};
      3'd1:    s = {"Friday", 24'h0};
      3'd2:    s = {"Saturday", 8'h00};
      3'd3:    s = {"Sunday", 24'h0};
      3'd4:    s = {"Monday", 24'h0};
      3'd5:    s = {"Tuesday", 16'h0};
      3'd6:    s = "Wednesday";
      default: s = 72'h0;
    endcase
    sh = s << {p, 3'b000};
    return sh[71:64];
  endfunction

  function automatic logic [8:0] mon_cum(input logic [3:0] m);
    logic [8:0] r;
    unique case (m)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd59;
      4'd3:    r = 9'd90;
      4'd4:    r = 9'd120;
      4'd5:    r = 9'd151;
      4'd6:    r = 9'd181;
      4'd7:    r = 9'd212;
      4'd8:    r = 9'd243;
      4'd9:    r = 9'd273;
      4'd10:   r = 9'd304;
      4'd11:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic tpl_t tpl_at(input logic [2:0] alive, input logic [4:0] p);
    tpl_t t;
    t.kind = K_END;
    t.lit  = 8'h00;
    t.fin  = 1'b0;
    if (alive == FMT_1123 || alive == FMT_850) begin
      unique case (p)
        5'd0:         begin t.kind = K_LIT; t.lit = ","; end
        5'd1, 5'd13, 5'd22: begin t.kind = K_LIT; t.lit = " "; end
        5'd2, 5'd3:   t.kind = K_DAY;
        5'd4, 5'd8: begin
          if (alive == FMT_850) begin
            t.kind = K_LIT;
            t.lit  = "-";
          end else begin
            t.kind = K_SEP;
          end
        end
        5'd5, 5'd6:   t.kind = K_MON;
        5'd7:         t.kind = K_MONLAST;
        5'd9, 5'd10, 5'd11, 5'd12: t.kind = K_YEAR;
        5'd14, 5'd15: t.kind = K_HOUR;
        5'd16, 5'd19: begin t.kind = K_LIT; t.lit = ":"; end
        5'd17, 5'd18: t.kind = K_MIN;
        5'd20, 5'd21: t.kind = K_SEC;
        5'd23:        begin t.kind = K_LIT; t.lit = "G"; end
        5'd24:        begin t.kind = K_LIT; t.lit = "M"; end
        5'd25:        begin t.kind = K_LIT; t.lit = "T"; t.fin = 1'b1; end
        default:      t.kind = K_END;
      endcase
    end else begin
      unique case (p)
        5'd0, 5'd4, 5'd7, 5'd16: begin t.kind = K_LIT; t.lit = " "; end
        5'd1, 5'd2:   t.kind = K_MON;
        5'd3:         t.kind = K_MONLAST;
        5'd5:         t.kind = K_DAYSP;
        5'd6:         t.kind = K_DAY;
        5'd8, 5'd9:   t.kind = K_HOUR;
        5'd10, 5'd13: begin t.kind = K_LIT; t.lit = ":"; end
        5'd11, 5'd12: t.kind = K_MIN;
        5'd14, 5'd15: t.kind = K_SEC;
        5'd17, 5'd18, 5'd19: t.kind = K_YEAR;
        5'd20:        begin t.kind = K_YEAR; t.fin = 1'b1; end
        default:      t.kind = K_END;
      endcase
    end
    return t;
  endfunction

endpackage

### rtl/hdte_parse.sv
module hdte_parse (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              beat,
  input  logic [7:0]        char_code,
  input  logic              last_char,
  input  logic              allow_dash,
  output hdte_pkg::fields_t snap
);
  import hdte_pkg::*;

  logic [4:0]  pos_r, pos_nxt;
  logic [2:0]  alive_r, alive_nxt;
  logic [23:0] letters_r, letters_nxt;
  logic [2:0]  wd_r, wd_nxt;
  logic [3:0]  mon_r, mon_nxt;
  logic [6:0]  day_r, day_nxt;
  logic [13:0] year_r, year_nxt;
  logic [6:0]  hour_r, hour_nxt;
  logic [6:0]  min_r, min_nxt;
  logic [6:0]  sec_r, sec_nxt;
  logic        complete_r, complete_nxt;
  logic        failed_r, failed_nxt;
  logic        tail_r, tail_nxt;

  logic [3:0]  wd_hit;
  logic [4:0]  mon_hit;
  logic [3:0]  len;
  logic        dig;
  logic [3:0]  dv;
  logic        ok;
  tpl_t        tpl;

  function automatic logic [6:0] acc7(input logic [6:0] v, input logic [3:0] d);
    return 7'({v, 3'b000}) + 7'({v, 1'b0}) + 7'(d);
  endfunction

  function automatic logic [13:0] acc14(input logic [13:0] v, input logic [3:0] d);
    return 14'({v, 3'b000}) + 14'({v, 1'b0}) + 14'(d);
  endfunction

  always_comb begin
    pos_nxt      = pos_r;
    alive_nxt    = alive_r;
    letters_nxt  = letters_r;
    wd_nxt       = wd_r;
    mon_nxt      = mon_r;
    day_nxt      = day_r;
    year_nxt     = year_r;
    hour_nxt     = hour_r;
    min_nxt      = min_r;
    sec_nxt      = sec_r;
    complete_nxt = complete_r;
    failed_nxt   = failed_r;
    tail_nxt     = tail_r;
    dig          = (char_code >= "0") && (char_code <= "9");
    dv           = 4'(char_code - "0");
    len          = wk_len(wd_r);
    tpl          = tpl_at(alive_r, pos_r);
    ok           = 1'b1;
    wd_hit       = wd_lookup({letters_r[15:0], char_code});
    mon_hit      = mon_lookup({letters_r[15:0], char_code});
    if (!failed_r && !complete_r) begin
      if (!tail_r) begin
        // weekday name
        if (pos_r < 5'd3) begin
          letters_nxt = {letters_r[15:0], char_code};
          if (pos_r == 5'd2 && !wd_hit[3]) begin
            failed_nxt = 1'b1;
          end else begin
            if (pos_r == 5'd2) begin
              wd_nxt = wd_hit[2:0];
            end
            pos_nxt = pos_r + 5'd1;
          end
        end else if (pos_r == 5'd3 && char_code == ",") begin
          alive_nxt = FMT_1123;
          tail_nxt  = 1'b1;
          pos_nxt   = 5'd1;
        end else if (pos_r == 5'd3 && char_code == " ") begin
          alive_nxt = FMT_ASC;
          tail_nxt  = 1'b1;
          pos_nxt   = 5'd1;
        end else begin
          if (pos_r == 5'd3) begin
            alive_nxt = FMT_850;
          end
          if (pos_r >= {1'b0, len} || char_code != wk_char(wd_r, pos_r[3:0])) begin
            failed_nxt = 1'b1;
          end else if (pos_r + 5'd1 == {1'b0, len}) begin
            tail_nxt = 1'b1;
            pos_nxt  = 5'd0;
          end else begin
            pos_nxt = pos_r + 5'd1;
          end
        end
      end else begin
        // date and time after the name
        unique case (tpl.kind)
          K_DAY:   if (dig) day_nxt = acc7(day_r, dv); else ok = 1'b0;
          K_DAYSP: if (dig) day_nxt = acc7(day_r, dv); else ok = (char_code == " ");
          K_YEAR:  if (dig) year_nxt = acc14(year_r, dv); else ok = 1'b0;
          K_HOUR:  if (dig) hour_nxt = acc7(hour_r, dv); else ok = 1'b0;
          K_MIN:   if (dig) min_nxt = acc7(min_r, dv); else ok = 1'b0;
          K_SEC:   if (dig) sec_nxt = acc7(sec_r, dv); else ok = 1'b0;
          K_SEP:   ok = (char_code == " ") || (allow_dash && char_code == "-");
          K_MON:   letters_nxt = {letters_r[15:0], char_code};
          K_MONLAST: begin
            letters_nxt = {letters_r[15:0], char_code};
            if (mon_hit[4]) mon_nxt = mon_hit[3:0]; else ok = 1'b0;
          end
          K_LIT:   ok = (char_code == tpl.lit);
          K_END:   ok = 1'b0;
          default: ok = 1'b0;
        endcase
        if (!ok) begin
          failed_nxt = 1'b1;
        end else begin
          if (tpl.fin) complete_nxt = 1'b1;
          pos_nxt = pos_r + 5'd1;
        end
      end
    end
    snap.failed   = failed_nxt;
    snap.complete = complete_nxt;
    snap.wd       = wd_nxt;
    snap.mon      = mon_nxt;
    snap.day      = day_nxt;
    snap.year     = year_nxt;
    snap.hour     = hour_nxt;
    snap.minute   = min_nxt;
    snap.second   = sec_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (beat && last_char)) begin
      pos_r      <= '0;
      alive_r    <= FMT_ALL;
      letters_r  <= '0;
      wd_r       <= '0;
      mon_r      <= '0;
      day_r      <= '0;
      year_r     <= '0;
      hour_r     <= '0;
      min_r      <= '0;
      sec_r      <= '0;
      complete_r <= 1'b0;
      failed_r   <= 1'b0;
      tail_r     <= 1'b0;
    end else if (beat) begin
      pos_r      <= pos_nxt;
      alive_r    <= alive_nxt;
      letters_r  <= letters_nxt;
      wd_r       <= wd_nxt;
      mon_r      <= mon_nxt;
      day_r      <= day_nxt;
      year_r     <= year_nxt;
      hour_r     <= hour_nxt;
      min_r      <= min_nxt;
      sec_r      <= sec_nxt;
      complete_r <= complete_nxt;
      failed_r   <= failed_nxt;
      tail_r     <= tail_nxt;
    end
  end

endmodule

### rtl/http_date_to_epoch_parser.sv
// channel  direction  payload                          handshake
// in_      input      char_code[7:0], last_char        in_valid / in_ready
// out_     output     epoch_seconds[39:0], status[1:0] out_valid / out_ready
// cfg_     input      apb write/read of allow_dash     psel, penable, pready=1
//
// one character beat is taken per cycle while in_ready is high; the parser updates its state in that cycle
// a beat with last_char enters a five-register epoch pipeline that carries the
// days*86400 multiply and the mod-7 reduction
// each pipeline stage holds its item under output stall and in_ready drops only
// when every stage is full; rst_n is synchronous, active low, and clears all control
module http_date_to_epoch_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_char_code,
  input  logic        in_last_char,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [39:0] out_epoch_seconds,
  output logic [1:0]  out_status,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import hdte_pkg::*;

  // config register
  logic allow_dash_r;
  logic cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = (cfg_paddr[2] == REG_ALLOW_DASH) ? {31'd0, allow_dash_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      allow_dash_r <= 1'b1;
    end else if (cfg_wr && cfg_paddr[2] == REG_ALLOW_DASH) begin
      allow_dash_r <= cfg_pwdata[0];
    end
  end

  // stage valids and ready chain
  logic v0_r, v1_r, v2_r, v3_r, vo_r;
  logic rdy_o, rdy3, rdy2, rdy1, rdy0;
  logic beat;

  assign rdy_o    = !vo_r || out_ready;
  assign rdy3     = !v3_r || rdy_o;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign rdy0     = !v0_r || rdy1;
  assign in_ready = rdy0;
  assign beat     = in_valid && in_ready;
  assign out_valid = vo_r;

  // character parser
  fields_t snap;
  fields_t f0_r;

  hdte_parse u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .beat       (beat),
    .char_code  (in_char_code),
    .last_char  (in_last_char),
    .allow_dash (allow_dash_r),
    .snap       (snap)
  );

  // stage 1: day count and time of day
  logic [1:0]         st1_nxt, st1_r;
  logic [13:0]        yd;
  logic [23:0]        days_u;
  logic signed [24:0] days1_nxt, days1_r;
  logic [18:0]        tod1_nxt, tod1_r;
  logic [2:0]         wd1_r;
  logic               leap;

  always_comb begin
    if (f0_r.failed || !f0_r.complete) begin
      st1_nxt = ST_SYNTAX;
    end else if (f0_r.year < YEAR_BASE) begin
      st1_nxt = ST_YEAR;
    end else begin
      st1_nxt = ST_OK;
    end
    yd        = f0_r.year - YEAR_BASE;
    leap      = (f0_r.mon >= 4'd2) && (f0_r.year[1:0] == 2'b00);
    // leap days in earlier years are (yd+1)/4
    days_u    = 24'(yd * 9'd365) + 24'((15'(yd) + 15'd1) >> 2)
              + 24'(mon_cum(f0_r.mon)) + 24'(leap) + 24'(f0_r.day);
    days1_nxt = $signed({1'b0, days_u}) - 25'sd1;
    tod1_nxt  = 19'(f0_r.hour * 12'd3600) + 19'(f0_r.minute * 6'd60) + 19'(f0_r.second);
  end

  // stage 2: seconds of whole days, and whole days spilled by the time of day
  logic signed [42:0] prod2_nxt, prod2_r;
  logic signed [24:0] dn2_nxt, dn2_r;
  logic [2:0]         q;
  logic [18:0]        tod2_r;
  logic [1:0]         st2_r;
  logic [2:0]         wd2_r;

  always_comb begin
    prod2_nxt = days1_r * $signed({1'b0, 17'(SEC_PER_DAY)});
    priority if (tod1_r >= 19'(5 * SEC_PER_DAY)) q = 3'd5;
    else if (tod1_r >= 19'(4 * SEC_PER_DAY))     q = 3'd4;
    else if (tod1_r >= 19'(3 * SEC_PER_DAY))     q = 3'd3;
    else if (tod1_r >= 19'(2 * SEC_PER_DAY))     q = 3'd2;
    else if (tod1_r >= 19'(SEC_PER_DAY))         q = 3'd1;
    else                                         q = 3'd0;
    // floor(total / 86400), negative exactly when total is
    dn2_nxt = days1_r + $signed({22'd0, q});
  end

  // stage 3: total seconds and octal digit sum toward mod 7
  logic signed [42:0] total3;
  logic [39:0]        total3_r;
  logic               neg3_r;
  logic [5:0]         ds3_nxt, ds3_r;
  logic [1:0]         st3_r;
  logic [2:0]         wd3_r;

  always_comb begin
    total3  = prod2_r + $signed({24'd0, tod2_r});
    ds3_nxt = '0;
    for (int i = 0; i < 8; i++) begin
      ds3_nxt = ds3_nxt + 6'(dn2_r[3*i +: 3]);
    end
  end

  // stage 4: weekday check and final status
  logic [3:0]  s2;
  logic [3:0]  m7a;
  logic [2:0]  m7;
  logic [1:0]  sto_nxt, sto_r;
  logic [39:0] epo_nxt, epo_r;

  always_comb begin
    s2  = 4'(ds3_r[5:3]) + 4'(ds3_r[2:0]);
    m7a = (s2 >= 4'd7) ? s2 - 4'd7 : s2;
    m7  = (m7a == 4'd7) ? 3'd0 : m7a[2:0];
    epo_nxt = '0;
    if (st3_r != ST_OK) begin
      sto_nxt = st3_r;
    end else if (neg3_r) begin
      sto_nxt = ST_YEAR;
    end else if (m7 != wd3_r) begin
      sto_nxt = ST_WDAY;
    end else begin
      sto_nxt = ST_OK;
      epo_nxt = total3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      if (rdy0) v0_r <= beat && in_last_char;
      if (rdy1) v1_r <= v0_r;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy_o) vo_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy0 && beat && in_last_char) begin
      f0_r <= snap;
    end
    if (rdy1 && v0_r) begin
      st1_r   <= st1_nxt;
      days1_r <= days1_nxt;
      tod1_r  <= tod1_nxt;
      wd1_r   <= f0_r.wd;
    end
    if (rdy2 && v1_r) begin
      prod2_r <= prod2_nxt;
      dn2_r   <= dn2_nxt;
      tod2_r  <= tod1_r;
      st2_r   <= st1_r;
      wd2_r   <= wd1_r;
    end
    if (rdy3 && v2_r) begin
      total3_r <= total3[39:0];
      neg3_r   <= dn2_r[24];
      ds3_r    <= ds3_nxt;
      st3_r    <= st2_r;
      wd3_r    <= wd2_r;
    end
    if (rdy_o && v3_r) begin
      sto_r <= sto_nxt;
      epo_r <= epo_nxt;
    end
  end

  assign out_status        = sto_r;
  assign out_epoch_seconds = epo_r;

`ifndef SYNTH
  // a failed result never carries a time value
  a_zero_on_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_OK || out_epoch_seconds == 40'd0))
    else $error("nonzero epoch with error status");

  // input backpressure only once the whole pipeline is full
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready && v0_r && v1_r && v2_r && v3_r))
    else $error("input stalled with room in the pipeline");

  // register write lands
  a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_wr && cfg_paddr[2] == REG_ALLOW_DASH) |=> (allow_dash_r == $past(cfg_pwdata[0])))
    else $error("config write lost");
`endif

endmodule
